// File: hw/rtl/mtfp_pkg.sv
// Shared types and constants for the Modbus TCP frame parser.
package mtfp_pkg;

    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned LENGTH_ADJ   = 6;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_SHORT       = 2'd1;
    localparam logic [1:0] ST_LENGTH      = 2'd2;
    localparam logic [1:0] ST_TRANSACTION = 2'd3;

    localparam int unsigned POS_TID_HI = 0;
    localparam int unsigned POS_TID_LO = 1;
    localparam int unsigned POS_LEN_HI = 4;
    localparam int unsigned POS_LEN_LO = 5;
    localparam int unsigned POS_ADDR   = 6;
    localparam int unsigned POS_FUNC   = 7;

    localparam int unsigned PADDR_BITS = 3;
    localparam logic        REG_EXP_TID = 1'b0;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_rx_item;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [7:0]  unit_address;
        logic [7:0]  function_code;
        logic [15:0] payload_length;
        logic [1:0]  status;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [7:0]  data;
        logic        has_payload;
        logic        has_end;
        logic [1:0]  status;
        logic [7:0]  unit_address;
        logic [7:0]  function_code;
        logic [15:0] payload_length;
    } t_op;

endpackage

// File: hw/rtl/mtfp_fifo.sv
// Small register queue of classified bytes between the front and back parts.
module mtfp_fifo
    import mtfp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_en,
    input  t_op  i_wr_data,
    output logic o_full,
    input  logic i_rd_en,
    output t_op  o_rd_data,
    output logic o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    t_op           r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign n_wr_ptr  = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr  = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_rd_en) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_wr_en, i_rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hw/rtl/mtfp_front.sv
// Front part: accepts frame bytes, captures the header and classifies each byte.
module mtfp_front
    import mtfp_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_expected_tid,
    input  logic        i_accept,
    input  t_rx_item    i_item,
    output logic        o_op_valid,
    output t_op         o_op
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] r_count;
    logic [15:0]           r_tid;
    logic [15:0]           r_len;
    logic [7:0]            r_addr;
    logic [7:0]            r_func;

    logic [COUNT_BITS-1:0] n_count;
    logic [15:0]           n_tid;
    logic [15:0]           n_len;
    logic [7:0]            n_addr;
    logic [7:0]            n_func;
    logic [COUNT_BITS-1:0] w_len_total;
    logic [1:0]            w_status;
    logic                  w_payload;

    always_comb begin
        n_tid  = r_tid;
        n_len  = r_len;
        n_addr = r_addr;
        n_func = r_func;
        if (r_count == COUNT_BITS'(POS_TID_HI)) begin
            n_tid[15:8] = i_item.rx_byte;
        end
        if (r_count == COUNT_BITS'(POS_TID_LO)) begin
            n_tid[7:0] = i_item.rx_byte;
        end
        if (r_count == COUNT_BITS'(POS_LEN_HI)) begin
            n_len[15:8] = i_item.rx_byte;
        end
        if (r_count == COUNT_BITS'(POS_LEN_LO)) begin
            n_len[7:0] = i_item.rx_byte;
        end
        if (r_count == COUNT_BITS'(POS_ADDR)) begin
            n_addr = i_item.rx_byte;
        end
        if (r_count == COUNT_BITS'(POS_FUNC)) begin
            n_func = i_item.rx_byte;
        end
    end

    assign n_count     = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;
    assign w_payload   = (r_count >= COUNT_BITS'(HEADER_BYTES));
    assign w_len_total = COUNT_BITS'(n_len) + COUNT_BITS'(LENGTH_ADJ);

    always_comb begin
        if (n_count < COUNT_BITS'(HEADER_BYTES)) begin
            w_status = ST_SHORT;
        end else if (n_count != w_len_total) begin
            w_status = ST_LENGTH;
        end else if (n_tid != i_expected_tid) begin
            w_status = ST_TRANSACTION;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        o_op             = '0;
        o_op.data        = i_item.rx_byte;
        o_op.has_payload = w_payload;
        o_op.has_end     = i_item.last_byte;
        o_op.status      = w_status;
        if (w_status == ST_OK) begin
            o_op.unit_address   = n_addr;
            o_op.function_code  = n_func;
            o_op.payload_length = n_len - 16'd2;
        end
    end

    assign o_op_valid = i_accept && (w_payload || i_item.last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tid   <= '0;
            r_len   <= '0;
            r_addr  <= '0;
            r_func  <= '0;
        end else if (i_accept) begin
            if (i_item.last_byte) begin
                r_count <= '0;
                r_tid   <= '0;
                r_len   <= '0;
                r_addr  <= '0;
                r_func  <= '0;
            end else begin
                r_count <= n_count;
                r_tid   <= n_tid;
                r_len   <= n_len;
                r_addr  <= n_addr;
                r_func  <= n_func;
            end
        end
    end

endmodule

// File: hw/rtl/mtfp_back.sv
// Back part: expands queued entries into payload and end results in an output register.
module mtfp_back
    import mtfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_op     i_q_data,
    input  logic    i_q_empty,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic    r_valid;
    logic    r_half;
    t_result r_result;

    logic    w_load;
    logic    w_split;
    logic    w_emit_end;
    t_result w_next;

    assign w_load     = (!r_valid || i_pop) && !i_q_empty;
    assign w_split    = i_q_data.has_payload && i_q_data.has_end && !r_half;
    assign w_emit_end = r_half || !i_q_data.has_payload;
    assign o_q_pop    = w_load && !w_split;

    always_comb begin
        w_next = '0;
        if (w_emit_end) begin
            w_next.unit_address   = i_q_data.unit_address;
            w_next.function_code  = i_q_data.function_code;
            w_next.payload_length = i_q_data.payload_length;
            w_next.status         = i_q_data.status;
            w_next.last           = 1'b1;
        end else begin
            w_next.payload_byte = i_q_data.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_half  <= w_split;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_empty  = !r_valid;
    assign o_result = r_result;

endmodule

// File: hw/rtl/modbus_tcp_frame_parser.sv
// Modbus TCP frame parser: MBAP header capture, payload forwarding and status check.
// Takes one frame byte per cycle unless full, no gaps required; a byte is classified
// in the cycle it is accepted and its results are queued for the output register.
// A byte that ends a frame from offset 8 on yields two results (payload, then
// end), which the output side drains at one per cycle, so the sustained rate is one
// byte per cycle whenever the consumer pops every cycle. Payload bytes leave before
// the frame is checked: discard them when the end result carries a bad status.
// The expected transaction ID sits at byte address 0 of the register port.
module modbus_tcp_frame_parser
    import mtfp_pkg::*;
#(
    parameter int unsigned COUNT_BITS  = 17,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  push,
    output logic                  full,
    input  t_rx_item              i_rx_item,
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result
);

    logic [15:0] r_expected_tid;
    logic        w_accept;
    logic        w_op_valid;
    t_op         w_op;
    t_op         w_q_data;
    logic        w_q_full;
    logic        w_q_empty;
    logic        w_q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_BITS-1] == REG_EXP_TID) ? {16'd0, r_expected_tid} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_tid <= '0;
        end else if (psel && penable && pwrite && paddr[PADDR_BITS-1] == REG_EXP_TID) begin
            r_expected_tid <= pwdata[15:0];
        end
    end

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    mtfp_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_expected_tid (r_expected_tid),
        .i_accept       (w_accept),
        .i_item         (i_rx_item),
        .o_op_valid     (w_op_valid),
        .o_op           (w_op)
    );

    mtfp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_op_valid),
        .i_wr_data (w_op),
        .o_full    (w_q_full),
        .i_rd_en   (w_q_pop),
        .o_rd_data (w_q_data),
        .o_empty   (w_q_empty)
    );

    mtfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (w_q_data),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule
